>>> design/hsls_pkg.sv
// Shared types and constants for the HSL lightness shift block.
// Depends on nothing; every other design file imports it.
`default_nettype none

package hsls_pkg;

    // Width of the divider operands: channel sums reach 510.
    localparam int DIV_W = 9;

    // Divisor of the lightness term, (max + min) / (2 * 255).
    localparam logic [DIV_W-1:0] L_DEN = 9'd510;

    // Reciprocal of 510 scaled by 2^27, rounded up. The product with any
    // operand below 2^18, shifted down by 27, is the exact floor quotient.
    localparam logic [18:0] L_RECIP    = 19'd263173;
    localparam int          L_RECIP_SH = 27;

    localparam logic [7:0] CH_MAX = 8'd255;

    // Hue sectors, 60 degrees each.
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       apply;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    // Classified pixel handed from the front end to the back end.
    typedef struct packed {
        logic [2:0]       sec;
        logic [7:0]       s_num;
        logic [7:0]       s_den;
        logic [7:0]       f_num;
        logic [7:0]       f_den;
        logic [DIV_W-1:0] sum;
        t_pix_in          pix;
    } t_work;

endpackage

`default_nettype wire

>>> design/hsls_front.sv
// Front end: registers an accepted pixel and classifies it (extremes, sector,
// divider operands). Depends on hsls_pkg.
`default_nettype none

module hsls_front
    import hsls_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_pix_in i_pixel,
    output logic         busy,
    input  wire logic    i_full,
    output logic         o_push,
    output t_work        o_work
);

    logic       r_valid;
    t_pix_in    r_item;
    logic       accept;
    logic [7:0] rr, gg, bb, mx, mn, dl;
    logic [8:0] sum, tt, dl2;
    logic signed [8:0] gb;
    logic [2:0] sec;
    logic [7:0] rem;

    assign busy   = r_valid & i_full;
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_pixel;
        end
    end

    always_comb begin
        rr  = r_item.red_in;
        gg  = r_item.green_in;
        bb  = r_item.blue_in;
        mx  = (rr > gg) ? rr : gg;
        mx  = (mx > bb) ? mx : bb;
        mn  = (rr < gg) ? rr : gg;
        mn  = (mn < bb) ? mn : bb;
        dl  = mx - mn;
        dl2 = {dl, 1'b0};
        sum = {1'b0, mx} + {1'b0, mn};
        gb  = $signed({1'b0, gg}) - $signed({1'b0, bb});
        tt  = 9'd0;
        sec = SEC_0;
        rem = 8'd0;
        if (dl == 8'd0) begin
            sec = SEC_0;
            rem = 8'd0;
        end else if (mx == rr) begin
            if (gb < 0) begin
                tt  = 9'(gb) + {1'b0, dl};
                sec = SEC_5;
                rem = tt[7:0];
            end else if (gb[7:0] >= dl) begin
                sec = SEC_1;
                rem = gb[7:0] - dl;
            end else begin
                sec = SEC_0;
                rem = gb[7:0];
            end
        end else if (mx == gg) begin
            tt = {1'b0, bb} - {1'b0, rr} + {1'b0, dl};
            if (tt >= dl2) begin
                sec = SEC_3;
                rem = 8'(tt - dl2);
            end else if (tt >= {1'b0, dl}) begin
                sec = SEC_2;
                rem = 8'(tt - {1'b0, dl});
            end else begin
                sec = SEC_1;
                rem = tt[7:0];
            end
        end else begin
            tt = {1'b0, rr} - {1'b0, gg} + {1'b0, dl};
            if (tt >= {1'b0, dl}) begin
                sec = SEC_4;
                rem = 8'(tt - {1'b0, dl});
            end else begin
                sec = SEC_3;
                rem = tt[7:0];
            end
        end
    end

    // A gray pixel divides zero by one, giving zero saturation and fraction.
    always_comb begin
        o_work.sec   = sec;
        o_work.sum   = sum;
        o_work.pix   = r_item;
        o_work.f_num = rem;
        if (dl == 8'd0) begin
            o_work.s_num = 8'd0;
            o_work.s_den = 8'd1;
            o_work.f_den = 8'd1;
        end else begin
            o_work.s_num = dl;
            o_work.s_den = (sum > {1'b0, CH_MAX}) ? 8'(L_DEN - sum) : sum[7:0];
            o_work.f_den = dl;
        end
    end

endmodule

`default_nettype wire

>>> design/hsls_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on hsls_pkg for the work record type.
`default_nettype none

module hsls_fifo
    import hsls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_work,
    output logic       o_full,
    output logic       o_valid,
    output t_work      o_work
);

    t_work      r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid;
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    // The back end drains one entry per cycle, so at most one is ever held.
    a_count_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd2)
        else $error("queue filled up");
    a_push_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push && o_valid |=> r_count == $past(r_count) - 2'd1)
        else $error("queue count went wrong");
`endif

endmodule

`default_nettype wire

>>> design/hsls_div.sv
// Pipelined restoring divider: q = floor(a * 2^FRAC / d) for a <= d,
// one quotient bit per stage. Depends on hsls_pkg for the operand width.
`default_nettype none

module hsls_div
    import hsls_pkg::*;
#(
    parameter int FRAC = 16
) (
    input  wire logic             i_clk,
    input  wire logic [DIV_W-1:0] i_a,
    input  wire logic [DIV_W-1:0] i_d,
    output logic [FRAC:0]         o_q
);

    logic [DIV_W-1:0] r_rem [0:FRAC-1];
    logic [DIV_W-1:0] r_den [0:FRAC-1];
    logic [FRAC:0]    r_quo [0:FRAC];
    logic             bit0;

    // The integer bit: the quotient reaches one only when a equals d.
    assign bit0 = (i_a >= i_d);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= bit0 ? (i_a - i_d) : i_a;
        r_den[0] <= i_d;
        r_quo[0] <= {{FRAC{1'b0}}, bit0};
    end

    for (genvar k = 1; k <= FRAC; k++) begin : g_stage
        logic [DIV_W:0] trial;
        logic           qbit;
        assign trial = {r_rem[k-1], 1'b0};
        assign qbit  = (trial >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            r_quo[k] <= {r_quo[k-1][FRAC-1:0], qbit};
        end
        if (k < FRAC) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= qbit ? DIV_W'(trial - {1'b0, r_den[k-1]}) : trial[DIV_W-1:0];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_q = r_quo[FRAC];

endmodule

`default_nettype wire

>>> design/hsls_back.sv
// Back end: works out lightness, saturation and hue fraction, applies the
// offset and rebuilds RGB. Depends on hsls_pkg and hsls_div.
`default_nettype none

module hsls_back
    import hsls_pkg::*;
#(
    parameter int FRAC = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_work              i_work,
    input  wire logic signed [17:0] i_offset,
    output logic                    o_valid,
    output t_pix_out                o_pixel
);

    localparam int LW = FRAC + 3;    // lightness after the offset
    localparam int CW = FRAC + 5;    // chroma and intermediate terms
    localparam logic signed [LW-1:0] ONE_L = LW'(1) <<< FRAC;
    localparam logic [FRAC:0]        ONE_U = (FRAC+1)'(1) << FRAC;

    // Lightness is (max + min) * 2^FRAC / 510. Splitting 2^FRAC into
    // L_Q * 510 + L_R leaves a remainder term below 2^18, which is divided
    // by 510 through the reciprocal multiply.
    localparam int unsigned L_Q = (32'd1 << FRAC) / 32'd510;
    localparam int unsigned L_R = (32'd1 << FRAC) % 32'd510;

    typedef struct packed {
        logic [2:0] sec;
        t_pix_in    pix;
    } t_side;

    logic [FRAC:0] q_l, q_s, q_f;
    t_side         r_side [0:FRAC];
    logic          r_vld  [0:FRAC];

    logic [17:0]   r_lp;
    logic [FRAC:0] r_lb;
    logic [FRAC:0] r_lum [1:FRAC];
    logic [36:0]   prod_l;

    assign prod_l = 37'(r_lp) * 37'(L_RECIP);

    // Lightness arithmetic in r_lp and r_lb, then in r_lum[1], followed by a
    // delay line that keeps the result in step with the dividers.
    always_ff @(posedge i_clk) begin
        r_lp     <= 18'(i_work.sum) * 18'(L_R);
        r_lb     <= (FRAC+1)'(i_work.sum) * (FRAC+1)'(L_Q);
        r_lum[1] <= r_lb + {{(FRAC-8){1'b0}}, prod_l[L_RECIP_SH+8:L_RECIP_SH]};
        for (int k = 2; k <= FRAC; k++) begin
            r_lum[k] <= r_lum[k-1];
        end
    end

    assign q_l = r_lum[FRAC];

    hsls_div #(.FRAC(FRAC)) u_div_s (
        .i_clk (i_clk),
        .i_a   ({1'b0, i_work.s_num}),
        .i_d   ({1'b0, i_work.s_den}),
        .o_q   (q_s)
    );

    hsls_div #(.FRAC(FRAC)) u_div_f (
        .i_clk (i_clk),
        .i_a   ({1'b0, i_work.f_num}),
        .i_d   ({1'b0, i_work.f_den}),
        .o_q   (q_f)
    );

    // Side data and valid travel alongside the divider stages.
    always_ff @(posedge i_clk) begin
        r_side[0] <= '{sec: i_work.sec, pix: i_work.pix};
        for (int k = 1; k <= FRAC; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FRAC; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= FRAC; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Offset brought from Q2.16 to the working fraction width.
    logic signed [LW-1:0] off_q;
    if (FRAC >= 16) begin : g_off_up
        assign off_q = $signed({{(FRAC-15){i_offset[17]}}, i_offset}) <<< (FRAC - 16);
    end else begin : g_off_down
        logic signed [17:0] off_sh;
        assign off_sh = i_offset >>> (16 - FRAC);
        assign off_q  = off_sh[LW-1:0];
    end

    logic                 r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [LW-1:0] r1_l2, r2_l2, r3_l2;
    logic [FRAC:0]        r1_s, r2_s;
    logic [FRAC-1:0]      r1_f, r2_f, r3_f;
    t_side                r1_side, r2_side, r3_side, r4_side;
    logic signed [CW-1:0] r2_cb, r3_c, r4_c, r4_x, r4_m;

    logic signed [CW-1:0]      two_l;
    logic signed [CW-1:0]      abs_t;
    logic signed [2*CW+1:0]    prod_c;
    logic [FRAC:0]             wgt;
    logic signed [CW+FRAC+1:0] prod_x;

    always_comb begin
        two_l  = (CW'(r1_l2) <<< 1) - CW'(ONE_L);
        abs_t  = (two_l < 0) ? -two_l : two_l;
        prod_c = (2*CW+2)'(r2_cb) * $signed({{(CW-FRAC){1'b0}}, r2_s});
        wgt    = r3_side.sec[0] ? (ONE_U - {1'b0, r3_f}) : {1'b0, r3_f};
        prod_x = (CW+FRAC+2)'(r3_c) * $signed({1'b0, wgt});
    end

    always_ff @(posedge i_clk) begin
        r1_l2   <= $signed({2'b00, q_l}) + off_q;
        r1_s    <= q_s;
        r1_f    <= q_f[FRAC-1:0];
        r1_side <= r_side[FRAC];

        r2_cb   <= CW'(ONE_L) - abs_t;
        r2_l2   <= r1_l2;
        r2_s    <= r1_s;
        r2_f    <= r1_f;
        r2_side <= r1_side;

        r3_c    <= prod_c[FRAC+CW-1:FRAC];
        r3_l2   <= r2_l2;
        r3_f    <= r2_f;
        r3_side <= r2_side;

        r4_c    <= r3_c;
        r4_x    <= prod_x[FRAC+CW-1:FRAC];
        r4_m    <= CW'(r3_l2) - (r3_c >>> 1);
        r4_side <= r3_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r1_vld  <= r_vld[FRAC];
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            o_valid <= r4_vld;
        end
    end

    // v * 255 / 2^FRAC, truncated and clamped to a channel value.
    function automatic logic [7:0] to_channel(input logic signed [CW:0] v);
        logic signed [CW+9:0] p;
        logic signed [CW+9:0] q;
        p = ((CW+10)'(v) <<< 8) - (CW+10)'(v);
        q = p >>> FRAC;
        if (v <= 0) begin
            return 8'd0;
        end else if (q > (CW+10)'(CH_MAX)) begin
            return CH_MAX;
        end else begin
            return q[7:0];
        end
    endfunction

    logic signed [CW-1:0] ch_r, ch_g, ch_b;

    always_comb begin
        case (r4_side.sec)
            SEC_0: begin
                ch_r = r4_c; ch_g = r4_x; ch_b = '0;
            end
            SEC_1: begin
                ch_r = r4_x; ch_g = r4_c; ch_b = '0;
            end
            SEC_2: begin
                ch_r = '0; ch_g = r4_c; ch_b = r4_x;
            end
            SEC_3: begin
                ch_r = '0; ch_g = r4_x; ch_b = r4_c;
            end
            SEC_4: begin
                ch_r = r4_x; ch_g = '0; ch_b = r4_c;
            end
            default: begin
                ch_r = r4_c; ch_g = '0; ch_b = r4_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r4_side.pix.apply) begin
            o_pixel.red_out   <= to_channel((CW+1)'(ch_r) + (CW+1)'(r4_m));
            o_pixel.green_out <= to_channel((CW+1)'(ch_g) + (CW+1)'(r4_m));
            o_pixel.blue_out  <= to_channel((CW+1)'(ch_b) + (CW+1)'(r4_m));
        end else begin
            o_pixel.red_out   <= r4_side.pix.red_in;
            o_pixel.green_out <= r4_side.pix.green_in;
            o_pixel.blue_out  <= r4_side.pix.blue_in;
        end
    end

endmodule

`default_nettype wire

>>> design/hsl_lightness_shift.sv
// Top level of the HSL lightness shift block: configuration register, front
// end, queue and back end. Depends on hsls_pkg and all hsls_* modules.
//
// Usage. A pixel is offered on i_pixel with start high; it is taken at a
// rising edge where start is high and busy is low. Pixels with apply low come
// out unchanged; pixels with apply high go through RGB to HSL, get the signed
// lightness offset added, and are rebuilt and clamped to 0..255.
// The lightness offset (signed Q2.16) is written through its own channel:
// the transfer happens at an edge with i_cfg_valid and o_cfg_ready high, and
// o_cfg_ready is always high. Write it only while no pixel is in flight.
// Throughput is one pixel per clock. An accepted pixel passes through
// classification in the front end, the queue, FRAC_BITS + 1 divider
// stages (one quotient bit each) and five reconstruction stages, the
// last of which registers the result and o_valid.
// Each result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall, so the back end drains the queue every cycle and busy stays
// low in operation. A synchronous active-low reset empties the pipeline and
// clears the offset to zero; no result appears from before the reset.
`default_nettype none

module hsl_lightness_shift
    import hsls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire t_pix_in     i_pixel,
    output logic             busy,
    output logic             o_valid,
    output t_pix_out         o_pixel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [17:0] i_cfg_data
);

    localparam int LATENCY = FRAC_BITS + 8;

    logic signed [17:0] r_offset;
    logic               push, full, q_valid;
    t_work              front_work, q_work;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_offset <= $signed(i_cfg_data);
        end
    end

    hsls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pixel (i_pixel),
        .busy    (busy),
        .i_full  (full),
        .o_push  (push),
        .o_work  (front_work)
    );

    hsls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    hsls_back #(.FRAC(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_work   (q_work),
        .i_offset (r_offset),
        .o_valid  (o_valid),
        .o_pixel  (o_pixel)
    );

`ifndef SYNTH
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("block stalled its input");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted pixel produced no result on time");
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");
`endif

endmodule

`default_nettype wire
